// File: hdl/vau_pkg.sv
// Package for the vector arithmetic unit.
// Holds the command codes used by the top level and its checker; no dependencies.
package vau_pkg;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_SCALE = 3'd2,
    CMD_DOT   = 3'd3,
    CMD_MAG   = 3'd4,
    CMD_NORM  = 3'd5
  } cmd_t;

endpackage

// File: hdl/vau_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on nothing; used by vector3_arithmetic_unit.
module vau_isqrt #(
  parameter int WORD_BITS = 32
) (
  input  logic                     clk,
  input  logic [2*WORD_BITS-1:0]   rad_i,
  output logic [WORD_BITS-1:0]     root_o
);

  localparam int RW = WORD_BITS + 2;

  logic [2*WORD_BITS-1:0] rad_in  [WORD_BITS];
  logic [RW-1:0]          rem_in  [WORD_BITS];
  logic [WORD_BITS-1:0]   root_in [WORD_BITS];
  logic [2*WORD_BITS-1:0] rad_r   [WORD_BITS];
  logic [RW-1:0]          rem_r   [WORD_BITS];
  logic [WORD_BITS-1:0]   root_r  [WORD_BITS];

  for (genvar k = 0; k < WORD_BITS; k++) begin : g_stage
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rad_in[k]  = rad_i;
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
    end else begin : g_next
      assign rad_in[k]  = rad_r[k-1];
      assign rem_in[k]  = rem_r[k-1];
      assign root_in[k] = root_r[k-1];
    end

    assign cur   = {rem_in[k], rad_in[k][2*WORD_BITS-1 -: 2]};
    assign trial = {2'b00, root_in[k], 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      rad_r[k]  <= {rad_in[k][2*WORD_BITS-3:0], 2'b00};
      rem_r[k]  <= ge ? RW'(cur - trial) : RW'(cur);
      root_r[k] <= {root_in[k][WORD_BITS-2:0], ge};
    end
  end

  assign root_o = root_r[WORD_BITS-1];

endmodule

// File: hdl/vau_div.sv
// Pipelined restoring unsigned divider, one quotient bit per register stage.
// Depends on nothing; used by vector3_arithmetic_unit.
module vau_div #(
  parameter int WORD_BITS = 32,
  parameter int NUM_BITS  = 63
) (
  input  logic                  clk,
  input  logic [NUM_BITS-1:0]   num_i,
  input  logic [WORD_BITS-1:0]  den_i,
  output logic [NUM_BITS-1:0]   quo_o
);

  logic [NUM_BITS-1:0]  nq_in  [NUM_BITS];
  logic [WORD_BITS-1:0] rem_in [NUM_BITS];
  logic [WORD_BITS-1:0] den_in [NUM_BITS];
  logic [NUM_BITS-1:0]  nq_r   [NUM_BITS];
  logic [WORD_BITS-1:0] rem_r  [NUM_BITS];
  logic [WORD_BITS-1:0] den_r  [NUM_BITS];

  for (genvar j = 0; j < NUM_BITS; j++) begin : g_stage
    logic [WORD_BITS:0] cur;
    logic               ge;

    if (j == 0) begin : g_first
      assign nq_in[j]  = num_i;
      assign rem_in[j] = '0;
      assign den_in[j] = den_i;
    end else begin : g_next
      assign nq_in[j]  = nq_r[j-1];
      assign rem_in[j] = rem_r[j-1];
      assign den_in[j] = den_r[j-1];
    end

    assign cur = {rem_in[j], nq_in[j][NUM_BITS-1]};
    assign ge  = (cur >= {1'b0, den_in[j]});

    always_ff @(posedge clk) begin
      nq_r[j]  <= {nq_in[j][NUM_BITS-2:0], ge};
      rem_r[j] <= ge ? WORD_BITS'(cur - {1'b0, den_in[j]}) : WORD_BITS'(cur);
      den_r[j] <= den_in[j];
    end
  end

  assign quo_o = nq_r[NUM_BITS-1];

endmodule

// File: hdl/vector3_arithmetic_unit.sv
// Top level of the three-component fixed-point vector unit.
// Depends on vau_pkg, vau_isqrt and vau_div.
//
// An item is taken at a rising edge where start is high and busy is low. It
// carries a command, vectors A and B and a scalar, all signed fixed point with
// FRACTION_BITS fraction bits. Commands are add, subtract, scale, dot product,
// magnitude and normalize; every result is saturated to the word range.
// Each item gives exactly one result, shown for one cycle with out_valid high.
// The path from the accepting edge to the result runs through the input
// registers, the square root pipeline (one root bit per stage), the divider
// pipeline (one quotient bit per stage) and the output register; every
// command takes the same path length. Throughput is one item per cycle once
// busy has gone low after reset; busy stays low until the next reset.
// The receiver cannot stall, so nothing is held back. A synchronous reset
// empties the pipeline and sets busy high; busy goes low at the first edge
// without reset. Results of a zero vector under normalize are zero with
// out_zero_length set.
module vector3_arithmetic_unit #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_command,
  input  logic signed [WORD_BITS-1:0] in_a_x,
  input  logic signed [WORD_BITS-1:0] in_a_y,
  input  logic signed [WORD_BITS-1:0] in_a_z,
  input  logic signed [WORD_BITS-1:0] in_b_x,
  input  logic signed [WORD_BITS-1:0] in_b_y,
  input  logic signed [WORD_BITS-1:0] in_b_z,
  input  logic signed [WORD_BITS-1:0] in_scalar_in,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] out_r_x,
  output logic signed [WORD_BITS-1:0] out_r_y,
  output logic signed [WORD_BITS-1:0] out_r_z,
  output logic signed [WORD_BITS-1:0] out_scalar_out,
  output logic                        out_overflow,
  output logic                        out_zero_length
);
  import vau_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int NB    = 2 * W - 1;
  localparam int WIDE  = 2 * W + 2;
  localparam int DEPTH = 3 + W + NB;
  localparam int ED    = W + NB;
  localparam int EW    = 4 * W + 4;
  localparam int NDW   = 3 * NB + 3;

  localparam logic signed [WIDE-1:0] MAX_WIDE = {{(WIDE-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [WIDE-1:0] MIN_WIDE = {{(WIDE-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0]  MAX_WORD = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MIN_WORD = {1'b1, {(W-1){1'b0}}};
  localparam logic [NB-1:0] LIM_POS  = {{(NB-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NB-1:0] LIM_NEG  = {{(NB-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  function automatic logic [W:0] sat_fn(input logic signed [WIDE-1:0] v);
    if (v > MAX_WIDE) begin
      return {1'b1, MAX_WORD};
    end else if (v < MIN_WIDE) begin
      return {1'b1, MIN_WORD};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic logic [W:0] norm_sat(input logic [NB-1:0] q, input logic neg);
    if (neg) begin
      if (q > LIM_NEG) begin
        return {1'b1, MIN_WORD};
      end
      return {1'b0, W'(~q[W-1:0] + 1'b1)};
    end
    if (q > LIM_POS) begin
      return {1'b1, MAX_WORD};
    end
    return {1'b0, q[W-1:0]};
  endfunction

  logic             busy_r;
  logic [DEPTH-1:0] vld_r;
  logic             accept;

  logic signed [W-1:0] a_s   [3];
  logic signed [W-1:0] b_s   [3];
  logic signed [W-1:0] mop_s [3];

  logic [2:0]            cmd1_r, cmd2_r;
  logic signed [W:0]     sum1_r [3];
  logic signed [2*W-1:0] pa1_r  [3];
  logic [2*W-1:0]        sq1_r  [3];

  logic signed [WIDE-1:0] dot2_r;
  logic [2*W-1:0]         sq2_r;
  logic signed [2*W-1:0]  sh2_r  [3];
  logic signed [W:0]      sum2_r [3];
  logic [NB-1:0]          num2_r [3];
  logic [2:0]             neg2_r;

  logic [EW-1:0]  early_nxt;
  logic [EW-1:0]  early_d [ED];
  logic [NDW-1:0] nd_d    [W];
  logic [W+2:0]   md_d    [NB];
  logic [W-1:0]   root;
  logic [NB-1:0]  quo [3];

  logic [W:0]     res_x, res_y, res_z, res_sc;
  logic           dot_ovf;

  logic [W-1:0] out_r_x_nxt, out_r_y_nxt, out_r_z_nxt, out_scalar_out_nxt;
  logic         out_overflow_nxt, out_zero_length_nxt;
  logic [W-1:0] out_r_x_r, out_r_y_r, out_r_z_r, out_scalar_out_r;
  logic         out_overflow_r, out_zero_length_r;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[DEPTH-2:0], accept};
    end
  end

  assign a_s[0] = in_a_x;
  assign a_s[1] = in_a_y;
  assign a_s[2] = in_a_z;
  assign b_s[0] = in_b_x;
  assign b_s[1] = in_b_y;
  assign b_s[2] = in_b_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mop_s[i] = (in_command == CMD_DOT) ? b_s[i] : in_scalar_in;
    end
  end

  always_ff @(posedge clk) begin
    cmd1_r <= in_command;
    for (int i = 0; i < 3; i++) begin
      if (in_command == CMD_SUB) begin
        sum1_r[i] <= (W+1)'(a_s[i]) - (W+1)'(b_s[i]);
      end else begin
        sum1_r[i] <= (W+1)'(a_s[i]) + (W+1)'(b_s[i]);
      end
      pa1_r[i] <= (2*W)'(a_s[i]) * (2*W)'(mop_s[i]);
      sq1_r[i] <= (2*W)'(a_s[i]) * (2*W)'(a_s[i]);
    end
  end

  always_ff @(posedge clk) begin
    cmd2_r <= cmd1_r;
    dot2_r <= WIDE'(pa1_r[0]) + WIDE'(pa1_r[1]) + WIDE'(pa1_r[2]);
    sq2_r  <= sq1_r[0] + sq1_r[1] + sq1_r[2];
    for (int i = 0; i < 3; i++) begin
      sh2_r[i]  <= pa1_r[i] >>> FRACTION_BITS;
      sum2_r[i] <= sum1_r[i];
      num2_r[i] <= pa1_r[i][2*W-1] ? NB'(-pa1_r[i]) : NB'(pa1_r[i]);
      neg2_r[i] <= pa1_r[i][2*W-1];
    end
  end

  always_comb begin
    logic [W:0] sx, sy, sz, sd;
    sx = '0;
    sy = '0;
    sz = '0;
    sd = '0;
    case (cmd2_r)
      CMD_ADD, CMD_SUB: begin
        sx = sat_fn(WIDE'(sum2_r[0]));
        sy = sat_fn(WIDE'(sum2_r[1]));
        sz = sat_fn(WIDE'(sum2_r[2]));
      end
      CMD_SCALE: begin
        sx = sat_fn(WIDE'(sh2_r[0]));
        sy = sat_fn(WIDE'(sh2_r[1]));
        sz = sat_fn(WIDE'(sh2_r[2]));
      end
      CMD_DOT: begin
        sd = sat_fn(dot2_r >>> FRACTION_BITS);
      end
      default: begin
        sd = '0;
      end
    endcase
    early_nxt = {cmd2_r, (sx[W] | sy[W] | sz[W] | sd[W]),
                 sx[W-1:0], sy[W-1:0], sz[W-1:0], sd[W-1:0]};
  end

  always_ff @(posedge clk) begin
    early_d[0] <= early_nxt;
    for (int k = 1; k < ED; k++) begin
      early_d[k] <= early_d[k-1];
    end
    nd_d[0] <= {neg2_r, num2_r[0], num2_r[1], num2_r[2]};
    for (int k = 1; k < W; k++) begin
      nd_d[k] <= nd_d[k-1];
    end
    md_d[0] <= {nd_d[W-1][NDW-1 -: 3], root};
    for (int k = 1; k < NB; k++) begin
      md_d[k] <= md_d[k-1];
    end
  end

  vau_isqrt #(.WORD_BITS(W)) u_isqrt (
    .clk    (clk),
    .rad_i  (sq2_r),
    .root_o (root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    vau_div #(.WORD_BITS(W), .NUM_BITS(NB)) u_div (
      .clk   (clk),
      .num_i (nd_d[W-1][(2-i)*NB +: NB]),
      .den_i (root),
      .quo_o (quo[i])
    );
  end

  always_comb begin
    logic [W-1:0] m;
    logic [2:0]   negs;
    logic [2:0]   cmd_e;
    m     = md_d[NB-1][W-1:0];
    negs  = md_d[NB-1][W+2:W];
    cmd_e = early_d[ED-1][EW-1 -: 3];
    res_x  = norm_sat(quo[0], negs[0]);
    res_y  = norm_sat(quo[1], negs[1]);
    res_z  = norm_sat(quo[2], negs[2]);
    res_sc = {m[W-1], m[W-1] ? MAX_WORD : m};
    dot_ovf = early_d[ED-1][4*W];
    out_r_x_nxt         = early_d[ED-1][4*W-1 -: W];
    out_r_y_nxt         = early_d[ED-1][3*W-1 -: W];
    out_r_z_nxt         = early_d[ED-1][2*W-1 -: W];
    out_scalar_out_nxt  = early_d[ED-1][W-1:0];
    out_overflow_nxt    = dot_ovf;
    out_zero_length_nxt = 1'b0;
    case (cmd_e)
      CMD_MAG: begin
        out_scalar_out_nxt = res_sc[W-1:0];
        out_overflow_nxt   = res_sc[W];
      end
      CMD_NORM: begin
        if (m == '0) begin
          out_r_x_nxt         = '0;
          out_r_y_nxt         = '0;
          out_r_z_nxt         = '0;
          out_overflow_nxt    = 1'b0;
          out_zero_length_nxt = 1'b1;
        end else begin
          out_r_x_nxt      = res_x[W-1:0];
          out_r_y_nxt      = res_y[W-1:0];
          out_r_z_nxt      = res_z[W-1:0];
          out_overflow_nxt = res_x[W] | res_y[W] | res_z[W];
        end
      end
      default: begin
        out_zero_length_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_r_x_r         <= out_r_x_nxt;
    out_r_y_r         <= out_r_y_nxt;
    out_r_z_r         <= out_r_z_nxt;
    out_scalar_out_r  <= out_scalar_out_nxt;
    out_overflow_r    <= out_overflow_nxt;
    out_zero_length_r <= out_zero_length_nxt;
  end

  assign out_valid       = vld_r[DEPTH-1];
  assign out_r_x         = out_r_x_r;
  assign out_r_y         = out_r_y_r;
  assign out_r_z         = out_r_z_r;
  assign out_scalar_out  = out_scalar_out_r;
  assign out_overflow    = out_overflow_r;
  assign out_zero_length = out_zero_length_r;

endmodule

// File: hdl/vau_chk.sv
// Port-level checker for the vector arithmetic unit, bound to the top level.
// Depends on vau_pkg and on the ports of vector3_arithmetic_unit.
module vau_chk #(
  parameter int WORD_BITS = 32
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic [2:0]           in_command,
  input logic                 out_valid,
  input logic [WORD_BITS-1:0] out_r_x,
  input logic [WORD_BITS-1:0] out_r_y,
  input logic [WORD_BITS-1:0] out_r_z,
  input logic                 out_overflow,
  input logic                 out_zero_length
);
  import vau_pkg::*;

  localparam int LAT = 3 * WORD_BITS + 2;

  a_result_had_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("Result without an accepted item.");

  a_zero_length_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_length) |->
      (out_r_x == '0 && out_r_y == '0 && out_r_z == '0 && !out_overflow))
    else $error("Zero-length result is not clean.");

  a_zero_length_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_length) |-> $past(in_command, LAT) == CMD_NORM)
    else $error("Zero-length flag on a command other than normalize.");

  a_scalar_no_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_command, LAT) == CMD_DOT ||
                   $past(in_command, LAT) == CMD_MAG)) |->
      (out_r_x == '0 && out_r_y == '0 && out_r_z == '0))
    else $error("Scalar command produced a vector.");

endmodule

bind vector3_arithmetic_unit vau_chk #(.WORD_BITS(WORD_BITS)) u_vau_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_command      (in_command),
  .out_valid       (out_valid),
  .out_r_x         (out_r_x),
  .out_r_y         (out_r_y),
  .out_r_z         (out_r_z),
  .out_overflow    (out_overflow),
  .out_zero_length (out_zero_length)
);
